// ----- sv/hcbp_pkg.sv -----
// Shared types and constants for the prefix-code bit packer.
// Used by huffman_code_bit_packer; no dependencies of its own.
package hcbp_pkg;

    localparam int SYM_W          = 8;
    localparam int LEN_W          = 6;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int PEND_W         = 7;
    localparam int PCNT_W         = 3;
    localparam int HARD_LEN_LIMIT = 32;
    localparam int TABLE_DEPTH    = 256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

endpackage

// ----- sv/huffman_code_bit_packer.sv -----
// Top level of the prefix-code bit packer: code table, bit packing, result buffer.
// Depends on hcbp_pkg and hcbp_ram.
//
// Each input beat is a load (write a symbol's code and length), an encode (append the
// symbol's code, first code bit first, to the pending bits and send every completed
// byte) or a flush (pad the pending bits with zeros to a byte and report the pad).
// The code table is read at the edge that takes a beat; the item then waits in the table
// stage until it is packed into the result register, from which its first result beat
// is presented. A new input beat is taken every cycle as long as each item gives at
// most one result beat and the receiver takes each beat; an encode that completes n
// bytes holds the result register until all n of its beats are taken, while loads and
// encodes that complete no byte pass through with no result. The single read port of
// the code table and the one-beat-per-cycle result register set that rate.
// Lengths above MAX_CODE_LEN (and above 32) saturate on load. An encode of a symbol
// with no code gives one beat with the error flag in m_tuser. Code lengths read as zero
// after reset through one valid flag per table entry: no clearing pass is needed.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40], zero
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], has_byte[8], pad_bits[11:9], zero
    output logic        m_tuser,   // status[0]
    output logic        m_tlast
);

    // Longest code the table keeps, and the sizes that follow from it.
    localparam int LenLimit = (MAX_CODE_LEN < hcbp_pkg::HARD_LEN_LIMIT) ?
                              MAX_CODE_LEN : hcbp_pkg::HARD_LEN_LIMIT;
    localparam int CodeW    = LenLimit;
    localparam int RamW     = CodeW + hcbp_pkg::LEN_W;
    localparam int MaxBytes = (LenLimit + hcbp_pkg::PEND_W) / hcbp_pkg::BYTE_W;
    localparam int BufW     = MaxBytes * hcbp_pkg::BYTE_W;
    localparam int CntW     = $clog2(MaxBytes + 1);
    localparam int TotW     = $clog2(LenLimit + hcbp_pkg::PEND_W + 1);
    localparam int StreamW  = CodeW + 2 * hcbp_pkg::PEND_W;

    // ---------------------------------------------------------------- input side
    logic                             s_beat;
    logic [hcbp_pkg::SYM_W-1:0]       in_sym;
    logic [hcbp_pkg::WORD_W-1:0]      in_word;
    logic [hcbp_pkg::LEN_W-1:0]       in_len;
    logic [hcbp_pkg::LEN_W-1:0]       in_len_sat;
    hcbp_pkg::op_t                    in_op;
    logic                             in_load;

    assign s_beat  = s_tvalid && s_tready;
    assign in_sym  = s_tdata[7:0];
    assign in_word = s_tdata[39:8];
    assign in_len  = s_tdata[45:40];
    assign in_op   = hcbp_pkg::op_t'(s_tuser);
    assign in_load = s_beat && (in_op == hcbp_pkg::OP_LOAD);

    // Saturate over-long loads to the table's limit.
    assign in_len_sat = (in_len > hcbp_pkg::LEN_W'(LenLimit)) ?
                        hcbp_pkg::LEN_W'(LenLimit) : in_len;

    // Code table: code and length of each symbol, one read per accepted beat.
    logic [RamW-1:0] ram_rd_data;

    hcbp_ram #(
        .WIDTH (RamW),
        .DEPTH (hcbp_pkg::TABLE_DEPTH)
    ) u_code_table (
        .aclk    (aclk),
        .wr_en   (in_load),
        .wr_addr (in_sym),
        .wr_data ({in_len_sat, in_word[CodeW-1:0]}),
        .rd_en   (s_beat),
        .rd_addr (in_sym),
        .rd_data (ram_rd_data)
    );

    // One flag per entry: an entry never loaded reads as length zero.
    logic [hcbp_pkg::TABLE_DEPTH-1:0] known_reg;
    logic [hcbp_pkg::TABLE_DEPTH-1:0] known_next;

    always_comb begin
        known_next = known_reg;
        if (in_load) begin
            known_next[in_sym] = 1'b1;
        end
    end

    // ---------------------------------------------------------------- table stage
    logic          a_valid_reg;
    logic          a_valid_next;
    hcbp_pkg::op_t a_op_reg;
    logic          a_known_reg;
    logic          b_advance;

    assign s_tready     = !a_valid_reg || b_advance;
    assign a_valid_next = s_beat ? 1'b1 : (b_advance ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            known_reg   <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            known_reg   <= known_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            a_op_reg    <= in_op;
            a_known_reg <= known_reg[in_sym];
        end
    end

    // ---------------------------------------------------------------- pack stage
    // Pending bits are held left-aligned; bits below the count are always zero.
    logic [hcbp_pkg::PEND_W-1:0] pend_reg;
    logic [hcbp_pkg::PEND_W-1:0] pend_next;
    logic [hcbp_pkg::PCNT_W-1:0] pcnt_reg;
    logic [hcbp_pkg::PCNT_W-1:0] pcnt_next;

    logic [CodeW-1:0]            a_code;
    logic [hcbp_pkg::LEN_W-1:0]  a_len;
    logic [CodeW-1:0]            code_left;
    logic [StreamW-1:0]          stream;
    logic [StreamW-1:0]          stream_rest;
    logic [TotW-1:0]             total;
    logic [CntW-1:0]             enc_bytes;
    logic [CntW-1:0]             n_new;
    logic                        is_encode;
    logic                        is_flush;
    logic                        unknown;

    assign a_code    = ram_rd_data[CodeW-1:0];
    assign a_len     = a_known_reg ? ram_rd_data[RamW-1 -: hcbp_pkg::LEN_W] : '0;
    assign is_encode = (a_op_reg == hcbp_pkg::OP_ENCODE);
    assign is_flush  = (a_op_reg == hcbp_pkg::OP_FLUSH);
    assign unknown   = (a_len == '0);

    // Left-align the code (drops bits above its length), then place it after the pending bits.
    assign code_left   = a_code << (hcbp_pkg::LEN_W'(LenLimit) - a_len);
    assign stream      = {pend_reg, {(CodeW + hcbp_pkg::PEND_W){1'b0}}}
                       | ({code_left, {(2 * hcbp_pkg::PEND_W){1'b0}}} >> pcnt_reg);
    assign total       = TotW'(pcnt_reg) + TotW'(a_len);
    assign enc_bytes   = CntW'(total >> 3);
    assign stream_rest = stream << {enc_bytes, 3'b000};

    always_comb begin
        unique case (a_op_reg)
            hcbp_pkg::OP_ENCODE: n_new = unknown ? CntW'(1) : enc_bytes;
            hcbp_pkg::OP_FLUSH:  n_new = CntW'(1);
            default:             n_new = '0;
        endcase
    end

    // ---------------------------------------------------------------- result buffer
    // Holds every result beat of one item; the head byte sits in the top bits.
    logic [BufW-1:0]             buf_reg;
    logic [BufW-1:0]             buf_next;
    logic [CntW-1:0]             cnt_reg;
    logic [CntW-1:0]             cnt_next;
    logic                        has_reg;
    logic                        has_next;
    logic [hcbp_pkg::PCNT_W-1:0] pad_reg;
    logic [hcbp_pkg::PCNT_W-1:0] pad_next;
    logic                        status_reg;
    logic                        status_next;
    logic                        m_beat;
    logic                        buf_free;
    logic                        load_buf;

    assign m_beat    = m_tvalid && m_tready;
    assign buf_free  = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_tready);
    assign b_advance = a_valid_reg && ((n_new == '0) || buf_free);
    assign load_buf  = b_advance && (n_new != '0);

    always_comb begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        has_next    = has_reg;
        pad_next    = pad_reg;
        status_next = status_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        if (m_beat) begin
            // Advance to the next completed byte.
            buf_next = buf_reg << hcbp_pkg::BYTE_W;
            cnt_next = cnt_reg - CntW'(1);
        end
        if (load_buf) begin
            cnt_next = n_new;
        end
        if (b_advance) begin
            priority if (is_encode && unknown) begin
                buf_next    = '0;
                has_next    = 1'b0;
                pad_next    = '0;
                status_next = 1'b1;
            end else if (is_encode) begin
                // Leave the buffer to drain when no byte completes.
                if (load_buf) begin
                    buf_next    = stream[StreamW-1 -: BufW];
                    has_next    = 1'b1;
                    pad_next    = '0;
                    status_next = 1'b0;
                end
                pend_next   = stream_rest[StreamW-1 -: hcbp_pkg::PEND_W];
                pcnt_next   = total[hcbp_pkg::PCNT_W-1:0];
            end else if (is_flush) begin
                buf_next    = {pend_reg, 1'b0, {(BufW - hcbp_pkg::BYTE_W){1'b0}}};
                has_next    = (pcnt_reg != '0);
                pad_next    = hcbp_pkg::PCNT_W'(0) - pcnt_reg;
                status_next = 1'b0;
                pend_next   = '0;
                pcnt_next   = '0;
            end else begin
                // Load or unused opcode: nothing to send, state holds.
                pend_next = pend_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        has_reg    <= has_next;
        pad_reg    <= pad_next;
        status_reg <= status_next;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == CntW'(1));
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, pad_reg, has_reg, buf_reg[BufW-1 -: hcbp_pkg::BYTE_W]};

    // ---------------------------------------------------------------- assertions
    a_pend_tail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg << pcnt_reg) == '0)
        else $error("pending bits below the count are not zero");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_advance && is_flush) |=> (pcnt_reg == '0) && (pend_reg == '0))
        else $error("flush did not empty the pending bits");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(MaxBytes))
        else $error("result buffer holds more beats than one item can give");

    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && !m_tdata[8] && (m_tdata[7:0] == 8'h00)))
        else $error("error beat carries data or is not last");

endmodule

// ----- sv/hcbp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for huffman_code_bit_packer: directed table, then random traffic.
// Depends on hcbp_pkg and the packer RTL; predicts every result beat in-line.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes as the package names them.
    localparam logic [1:0] OP_LOAD   = hcbp_pkg::OP_LOAD;
    localparam logic [1:0] OP_ENCODE = hcbp_pkg::OP_ENCODE;
    localparam logic [1:0] OP_FLUSH  = hcbp_pkg::OP_FLUSH;

    // Code length limit handed to the block; the predictor saturates to the same value.
    localparam int MAX_LEN   = 32;
    localparam int LEN_LIMIT = (MAX_LEN < hcbp_pkg::HARD_LEN_LIMIT) ?
                               MAX_LEN : hcbp_pkg::HARD_LEN_LIMIT;
    // The opcode that the package leaves unassigned; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int POOL_N    = 12;
    localparam int PHASE_N   = 167;
    localparam int MAX_SHOWN = 10;
    // Slack allowed after the owed beats have come back.
    localparam int SETTLE_CYCLES = 8;

    // One result beat, fields in the order they are printed.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] pad_bits;
        logic       status;
        logic       last;
    } beat_t;

    // One row of the directed table; 'typed' rows carry their single result beat.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] word;
        logic [5:0]  len;
        logic        typed;
        beat_t       want;
    } row_t;

    localparam beat_t NO_BEAT = '0;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // symbol[7:0], code_word[39:8], code_length[45:40], zero
    logic [1:0]  s_tuser  = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // out_byte[7:0], has_byte[8], pad_bits[11:9], zero
    logic        m_tuser;         // status[0]
    logic        m_tlast;

    int tx_idle_pct = 26;
    int rx_idle_pct = 83;
    int fault_count = 0;

    // Predictor state: its own copy of the code table and the bit buffer.
    logic [31:0] code_tab [hcbp_pkg::TABLE_DEPTH];
    logic [5:0]  len_tab  [hcbp_pkg::TABLE_DEPTH];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;

    // Result beats still owed by the block, oldest first.
    beat_t beats_due [$];

    logic [7:0] sym_pool [POOL_N];

    row_t dir_rows [25] = '{
        // flush straight after reset: nothing waiting, empty beat
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'h00, 1'b0, 3'd0, 1'b0, 1'b1}},
        // encode of symbols that never got a code: error beat
        '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'h00, 1'b0, 3'd0, 1'b1, 1'b1}},
        '{OP_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, {8'h00, 1'b0, 3'd0, 1'b1, 1'b1}},
        // unused opcode: nothing comes out, nothing changes
        '{OP_UNUSED, 8'h5A, 32'hFFFF_FFFF, 6'd63, 1'b0, NO_BEAT},
        '{OP_LOAD,   8'h00, 32'h0000_00A5, 6'd8,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'hA5, 1'b1, 3'd0, 1'b0, 1'b1}},
        // longest code: four bytes out of one encode
        '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0, NO_BEAT},
        '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_LOAD,   8'h01, 32'h0000_0005, 6'd3,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'hA0, 1'b1, 3'd5, 1'b0, 1'b1}},
        // over-long load saturates to the limit
        '{OP_LOAD,   8'h02, 32'h8000_0001, 6'd63, 1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        // code bits above the length are ignored: a one-bit code of zero
        '{OP_LOAD,   8'h03, 32'hFFFF_FFFE, 6'd1,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'h00, 1'b1, 3'd7, 1'b0, 1'b1}},
        // length zero removes the entry; the error must leave pending bits alone
        '{OP_LOAD,   8'h00, 32'hDEAD_BEEF, 6'd0,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, {8'h00, 1'b0, 3'd0, 1'b1, 1'b1}},
        '{OP_LOAD,   8'h04, 32'h1234_5678, 6'd40, 1'b0, NO_BEAT},
        '{OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_UNUSED, 8'h04, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT}
    };

    huffman_code_bit_packer #(
        .MAX_CODE_LEN (MAX_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Back-pressure from the receiving side, redrawn every cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Work out the result beats of one accepted input beat and advance the copy of state.
    task automatic pack_expect(input logic [1:0] op, input logic [7:0] sym,
                               input logic [31:0] word, input logic [5:0] len_in);
        logic [63:0] acc;
        logic [14:0] padded;
        int          len;
        int          total;
        beat_t       b;
        b = NO_BEAT;
        case (op)
            OP_LOAD: begin
                code_tab[sym] = word;
                len_tab[sym]  = (len_in > LEN_LIMIT) ? 6'(LEN_LIMIT) : len_in;
            end
            OP_ENCODE: begin
                len = len_tab[sym];
                if (len == 0) begin
                    // unknown symbol: one error beat, buffer untouched
                    b.status = 1'b1;
                    b.last   = 1'b1;
                    beats_due.push_back(b);
                end else begin
                    acc   = ({57'd0, pend_bits} << len) |
                            ({32'd0, code_tab[sym]} & ((64'd1 << len) - 64'd1));
                    total = pend_cnt + len;
                    while (total >= 8) begin
                        b.out_byte = 8'(acc >> (total - 8));
                        b.has_byte = 1'b1;
                        total      = total - 8;
                        b.last     = (total < 8);
                        beats_due.push_back(b);
                    end
                    pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                    pend_cnt  = 3'(total);
                end
            end
            OP_FLUSH: begin
                b.last = 1'b1;
                if (pend_cnt != 0) begin
                    b.pad_bits = 3'(8 - pend_cnt);
                    padded     = {8'd0, pend_bits} << (8 - pend_cnt);
                    b.out_byte = padded[7:0];
                    b.has_byte = 1'b1;
                end
                beats_due.push_back(b);
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: ;
        endcase
    endtask

    // Offer one beat from a falling edge; return on the falling edge after acceptance.
    task automatic push_beat(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] word, input logic [5:0] len,
                             input logic typed, input beat_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, len, word, sym};
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            // state still advances; the typed beat stands in for the predicted one
            pack_expect(op, sym, word, len);
            void'(beats_due.pop_back());
            beats_due.push_back(want);
        end else begin
            pack_expect(op, sym, word, len);
        end
        @(negedge aclk);
    endtask

    // Hold the sender off until every owed beat has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly encodes of loaded symbols, with loads, flushes and noise mixed in.
    task automatic run_phase(input int tx_pct, input int rx_pct);
        int         done;
        int         pick;
        logic [7:0] sym;
        logic [5:0] len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done        = 0;
        while (done < PHASE_N) begin
            pick = $urandom_range(99);
            sym  = ($urandom_range(99) < 85) ? sym_pool[$urandom_range(POOL_N - 1)]
                                              : 8'($urandom_range(255));
            if (pick < 12) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    len = 6'd0;
                else if (pick < 75)
                    len = 6'($urandom_range(9, 1));
                else if (pick < 93)
                    len = 6'($urandom_range(32, 10));
                else
                    len = 6'($urandom_range(63, 33));
                push_beat(OP_LOAD, sym, $urandom, len, 1'b0, NO_BEAT);
                done++;
            end else if (pick < 86) begin
                push_beat(OP_ENCODE, sym, $urandom, 6'($urandom_range(63)), 1'b0, NO_BEAT);
                done++;
            end else if (pick < 96) begin
                push_beat(OP_FLUSH, sym, $urandom, 6'($urandom_range(63)), 1'b0, NO_BEAT);
                done++;
            end else begin
                // ignored by the block, so not counted
                push_beat(OP_UNUSED, sym, $urandom, 6'($urandom_range(63)), 1'b0, NO_BEAT);
            end
        end
        drain();
    endtask

    function automatic string show_beat(input beat_t b);
        return $sformatf("byte=%02h has=%0d pad=%0d status=%0d last=%0d",
                         b.out_byte, b.has_byte, b.pad_bits, b.status, b.last);
    endfunction

    task automatic note_fault(input string what, input beat_t want, input beat_t got);
        fault_count++;
        if (fault_count <= MAX_SHOWN)
            $display("%0t: %s: want %s, got %s", $time, what, show_beat(want),
                     show_beat(got));
    endtask

    // Compare each result beat with the oldest one owed.
    always @(posedge aclk) begin : result_check
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[8], m_tdata[11:9], m_tuser, m_tlast};
            if (beats_due.size() == 0) begin
                note_fault("unexpected beat", NO_BEAT, got);
            end else begin
                want = beats_due.pop_front();
                if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                    got.pad_bits !== want.pad_bits || got.status !== want.status ||
                    got.last !== want.last)
                    note_fault("field mismatch", want, got);
            end
        end
    end

    // Stimulus: reset, directed table, then three idling regimes.
    initial begin
        for (int i = 0; i < hcbp_pkg::TABLE_DEPTH; i++) begin
            code_tab[i] = '0;
            len_tab[i]  = '0;
        end
        pend_bits = '0;
        pend_cnt  = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            push_beat(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].word, dir_rows[i].len,
                      dir_rows[i].typed, dir_rows[i].want);
        drain();

        // give a handful of symbols short codes so most encodes hit the table
        foreach (sym_pool[i]) begin
            sym_pool[i] = 8'($urandom_range(255));
            push_beat(OP_LOAD, sym_pool[i], $urandom, 6'($urandom_range(9, 1)), 1'b0,
                      NO_BEAT);
        end

        run_phase(26, 83);
        run_phase(83, 26);
        run_phase(0, 0);

        while (beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (beats_due.size() != 0)
            note_fault("beat never came", beats_due[0], NO_BEAT);

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Drop the run if it hangs; this is far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
